@@ design/mvt_pkg.sv @@
// shared types and constants for the 4x4 matrix vector transform unit
// no dependencies; imported by the lane, merge and top-level modules
package mvt_pkg;

   localparam int WORD_W = 32;
   localparam int PROD_W = 2 * WORD_W;
   localparam int PAIR_W = PROD_W + 1;
   localparam int SUM_W  = PROD_W + 2;
   localparam int DIM    = 4;
   localparam int ELEMS  = DIM * DIM;
   localparam int IDX_W  = $clog2(ELEMS);

   // transaction kinds
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_XFORM = 1'b1;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef word_type quad_type [DIM];
   typedef sum_type  sum_quad_type [DIM];

   // per-stage load enables for the lane pipeline
   typedef struct packed {
      logic mul_en;
      logic pair_en;
      logic sum_en;
   } stage_ctl_type;

   // signed saturation bounds at sum width
   localparam sum_type SAT_HI = {{(SUM_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
   localparam sum_type SAT_LO = {{(SUM_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};

endpackage

@@ design/mvt_lane.sv @@
// one dot-product lane: four 32x32 products, pairwise add, final add
// depends on mvt_pkg for word, sum and stage control types
module mvt_lane (
   input  logic                   clock,
   input  mvt_pkg::stage_ctl_type ctl,
   input  mvt_pkg::quad_type      mat_row,
   input  mvt_pkg::quad_type      vec,
   output mvt_pkg::sum_type       sum
);
   import mvt_pkg::*;

   logic signed [PROD_W-1:0] prod_in [DIM];
   logic signed [PROD_W-1:0] prod_ff [DIM];
   logic signed [PAIR_W-1:0] pair_in [2];
   logic signed [PAIR_W-1:0] pair_ff [2];
   sum_type                  sum_in;
   sum_type                  sum_ff;

   // exact signed products
   always_comb begin
      for (int k = 0; k < DIM; k++) begin
         prod_in[k] = PROD_W'(mat_row[k]) * PROD_W'(vec[k]);
      end
   end

   // pairwise sums
   always_comb begin
      pair_in[0] = PAIR_W'(prod_ff[0]) + PAIR_W'(prod_ff[1]);
      pair_in[1] = PAIR_W'(prod_ff[2]) + PAIR_W'(prod_ff[3]);
   end

   // full-width total
   assign sum_in = SUM_W'(pair_ff[0]) + SUM_W'(pair_ff[1]);

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         for (int k = 0; k < DIM; k++) begin
            prod_ff[k] <= prod_in[k];
         end
      end
      if (ctl.pair_en) begin
         pair_ff[0] <= pair_in[0];
         pair_ff[1] <= pair_in[1];
      end
      if (ctl.sum_en) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

@@ design/mvt_merge.sv @@
// merge stage: shift and saturate each lane sum, combine clip flags
// depends on mvt_pkg; holds the response output register
module mvt_merge #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_en,
   input  logic                  sum_valid,
   input  mvt_pkg::sum_quad_type lane_sum,
   output logic                  out_valid,
   output mvt_pkg::quad_type     out_res,
   output logic                  out_sat
);
   import mvt_pkg::*;

   sum_type  shifted [DIM];
   word_type res_in [DIM];
   logic     sat_in;
   word_type res_ff [DIM];
   logic     sat_ff;
   logic     valid_ff;
   logic     valid_in;

   // floor shift then clip to the signed word range
   always_comb begin
      sat_in = 1'b0;
      for (int i = 0; i < DIM; i++) begin
         shifted[i] = lane_sum[i] >>> FRAC_BITS;
         if (shifted[i] > SAT_HI) begin
            res_in[i] = SAT_HI[WORD_W-1:0];
            sat_in    = 1'b1;
         end else if (shifted[i] < SAT_LO) begin
            res_in[i] = SAT_LO[WORD_W-1:0];
            sat_in    = 1'b1;
         end else begin
            res_in[i] = shifted[i][WORD_W-1:0];
         end
      end
   end

   assign valid_in = load_en ? sum_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en && sum_valid) begin
         for (int i = 0; i < DIM; i++) begin
            res_ff[i] <= res_in[i];
         end
         sat_ff <= sat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_sat   = sat_ff;
   always_comb begin
      for (int i = 0; i < DIM; i++) begin
         out_res[i] = res_ff[i];
      end
   end

endmodule

@@ design/mat4_vector_transform_unit.sv @@
// 4x4 matrix times 4-vector, signed fixed point, four parallel lanes
// rsp_valid rises once a transform has passed the mul, pair, sum and merge registers
// one transaction per cycle unless stalled (multiply, pair add, sum, saturate stages)
// load transactions write one element at acceptance and produce no response
// synchronous reset loads the identity matrix and empties the pipeline
// depends on mvt_pkg, mvt_lane and mvt_merge
module mat4_vector_transform_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_mode,
   input  logic [3:0]              req_elem_index,
   input  logic signed [31:0]      req_elem_value,
   input  logic signed [31:0]      req_vec_x,
   input  logic signed [31:0]      req_vec_y,
   input  logic signed [31:0]      req_vec_z,
   input  logic signed [31:0]      req_vec_w,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [31:0]      rsp_res_x,
   output logic signed [31:0]      rsp_res_y,
   output logic signed [31:0]      rsp_res_z,
   output logic signed [31:0]      rsp_res_w,
   output logic                    rsp_saturated
);
   import mvt_pkg::*;

   word_type      store_ff [ELEMS];
   quad_type      vec;
   quad_type      mat_rows [DIM];
   sum_quad_type  lane_sum;
   quad_type      res;
   stage_ctl_type ctl;
   logic          out_en;
   logic          req_fire;
   logic          mul_valid_ff, pair_valid_ff, sum_valid_ff;
   logic          mul_valid_in, pair_valid_in, sum_valid_in;

   // backward stall chain: a stage loads when empty or when its successor loads
   always_comb begin
      out_en      = !rsp_valid || !rsp_stall;
      ctl.sum_en  = !sum_valid_ff || out_en;
      ctl.pair_en = !pair_valid_ff || ctl.sum_en;
      ctl.mul_en  = !mul_valid_ff || ctl.pair_en;
   end

   assign req_stall = !ctl.mul_en;
   assign req_fire  = req_valid && !req_stall;

   // stage valid bits
   always_comb begin
      mul_valid_in  = ctl.mul_en  ? (req_fire && (req_mode == MODE_XFORM)) : mul_valid_ff;
      pair_valid_in = ctl.pair_en ? mul_valid_ff  : pair_valid_ff;
      sum_valid_in  = ctl.sum_en  ? pair_valid_ff : sum_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff  <= 1'b0;
         pair_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         mul_valid_ff  <= mul_valid_in;
         pair_valid_ff <= pair_valid_in;
         sum_valid_ff  <= sum_valid_in;
      end
   end

   // matrix store, identity after reset, written by load transactions
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < ELEMS; e++) begin
            store_ff[e] <= (e % (DIM + 1) == 0) ? (WORD_W'(1) << FRAC_BITS) : '0;
         end
      end else if (req_fire && (req_mode == MODE_LOAD)) begin
         store_ff[req_elem_index] <= req_elem_value;
      end
   end

   // lane i sees row i: elements 4k+i of the column-major store
   always_comb begin
      vec[0] = req_vec_x;
      vec[1] = req_vec_y;
      vec[2] = req_vec_z;
      vec[3] = req_vec_w;
      for (int i = 0; i < DIM; i++) begin
         for (int k = 0; k < DIM; k++) begin
            mat_rows[i][k] = store_ff[DIM*k + i];
         end
      end
   end

   for (genvar g = 0; g < DIM; g++) begin : g_lane
      mvt_lane u_lane (
         .clock   (clock),
         .ctl     (ctl),
         .mat_row (mat_rows[g]),
         .vec     (vec),
         .sum     (lane_sum[g])
      );
   end

   mvt_merge #(
      .FRAC_BITS (FRAC_BITS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .load_en   (out_en),
      .sum_valid (sum_valid_ff),
      .lane_sum  (lane_sum),
      .out_valid (rsp_valid),
      .out_res   (res),
      .out_sat   (rsp_saturated)
   );

   assign rsp_res_x = res[0];
   assign rsp_res_y = res[1];
   assign rsp_res_z = res[2];
   assign rsp_res_w = res[3];

endmodule

@@ sim/tb.sv @@
// self-checking bench for mat4_vector_transform_unit: loads and vector transforms
// checked against a bit-accurate fixed-point matrix model kept in the bench
// depends on mvt_pkg and the rtl of the transform unit
module tb;
   import mvt_pkg::*;

   localparam int FRAC_BITS  = 16;
   localparam int RAND_ITEMS = 900;
   localparam int HOLD_AT    = 450;
   localparam int HOLD_LEN   = 120;

   localparam word_type W_MAX = 32'h7FFF_FFFF;
   localparam word_type W_MIN = 32'h8000_0000;
   localparam word_type ONE_Q = 32'h0001_0000;
   localparam logic signed [65:0] RES_MAX = 66'sd2147483647;
   localparam logic signed [65:0] RES_MIN = -RES_MAX - 66'sd1;

   typedef struct {
      logic       mode;
      logic [3:0] idx;
      word_type   value;
      word_type   vec [DIM];
      int         pre_idle;
      bit         wait_drain;
   } mvt_cmd_type;

   typedef struct {
      word_type comp [DIM];
      logic     sat;
   } xform_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_mode = MODE_LOAD;
   logic [3:0] req_elem_index = '0;
   logic signed [31:0] req_elem_value = '0;
   logic signed [31:0] req_vec_x = '0;
   logic signed [31:0] req_vec_y = '0;
   logic signed [31:0] req_vec_z = '0;
   logic signed [31:0] req_vec_w = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_res_x;
   logic signed [31:0] rsp_res_y;
   logic signed [31:0] rsp_res_z;
   logic signed [31:0] rsp_res_w;
   logic rsp_saturated;

   mvt_cmd_type      mvt_cmds [$];
   xform_result_type transform_due [$];
   word_type         shadow_matrix [ELEMS];
   string            comp_name [DIM] = '{"res_x", "res_y", "res_z", "res_w"};

   logic req_fired = 1'b0;
   bit   no_gaps = 1'b0;
   bit   drain_next = 1'b0;
   int   n_errors = 0;
   int   n_accepted = 0;
   int   n_loads = 0;
   int   n_checked = 0;
   int   n_clipped = 0;

   // receiver stall state
   int  hold_left = 0;
   bit  holdoff_done = 1'b0;
   int  stall_left = 0;
   int  free_left = 0;

   mat4_vector_transform_unit #(
      .FRAC_BITS(FRAC_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_elem_index(req_elem_index),
      .req_elem_value(req_elem_value),
      .req_vec_x(req_vec_x),
      .req_vec_y(req_vec_y),
      .req_vec_z(req_vec_z),
      .req_vec_w(req_vec_w),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_res_x(rsp_res_x),
      .rsp_res_y(rsp_res_y),
      .rsp_res_z(rsp_res_z),
      .rsp_res_w(rsp_res_w),
      .rsp_saturated(rsp_saturated)
   );

   always #2 clock = ~clock;

   // matrix times vector: full-width sum, floor shift, clip to 32 bits
   function automatic xform_result_type apply_matrix(input word_type vin [DIM]);
      xform_result_type res;
      logic signed [65:0] acc;
      logic signed [65:0] m_elem;
      logic signed [65:0] v_elem;
      logic signed [65:0] shifted;
      int i;
      int k;
      res.sat = 1'b0;
      for (i = 0; i < DIM; i++) begin
         acc = '0;
         for (k = 0; k < DIM; k++) begin
            m_elem = shadow_matrix[DIM*k + i];
            v_elem = vin[k];
            acc = acc + m_elem * v_elem;
         end
         shifted = acc >>> FRAC_BITS;
         if (shifted > RES_MAX) begin
            shifted = RES_MAX;
            res.sat = 1'b1;
         end else if (shifted < RES_MIN) begin
            shifted = RES_MIN;
            res.sat = 1'b1;
         end
         res.comp[i] = shifted[31:0];
      end
      return res;
   endfunction

   // mix of full-range, small fixed-point and boundary values
   function automatic word_type rand_q();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         return $urandom();
      end else if (pick < 75) begin
         return $urandom_range(0, 2097152) - 1048576;
      end else if (pick < 90) begin
         return $urandom_range(0, 33554432) - 16777216;
      end
      case ($urandom_range(0, 6))
         0: return W_MAX;
         1: return W_MIN;
         2: return '0;
         3: return 32'sd1;
         4: return -32'sd1;
         5: return ONE_Q;
         default: return -ONE_Q;
      endcase
   endfunction

   // idle cycles ahead of a transaction, mostly short
   function automatic int pick_gap();
      int pick;
      if (no_gaps) begin
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         return 0;
      end else if (pick < 88) begin
         return $urandom_range(1, 3);
      end else if (pick < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(15, 50);
   endfunction

   task automatic push_cmd(input logic mode, input logic [3:0] idx, input word_type value,
                           input word_type vx, input word_type vy, input word_type vz,
                           input word_type vw);
      mvt_cmd_type cmd;
      cmd.mode = mode;
      cmd.idx = idx;
      cmd.value = value;
      cmd.vec = '{vx, vy, vz, vw};
      cmd.pre_idle = pick_gap();
      cmd.wait_drain = drain_next;
      drain_next = 1'b0;
      mvt_cmds.push_back(cmd);
   endtask

   // unused fields of each transaction carry random bits
   task automatic push_load(input logic [3:0] idx, input word_type value);
      push_cmd(MODE_LOAD, idx, value, $urandom(), $urandom(), $urandom(), $urandom());
   endtask

   task automatic push_xform(input word_type vx, input word_type vy, input word_type vz,
                             input word_type vw);
      push_cmd(MODE_XFORM, 4'($urandom()), $urandom(), vx, vy, vz, vw);
   endtask

   // sender: offers the next queued transaction once the current one is taken
   always @(negedge clock) begin
      mvt_cmd_type cmd;
      logic        next_valid;
      next_valid = req_valid;
      if (!reset && (!req_valid || req_fired)) begin
         next_valid = 1'b0;
         if (mvt_cmds.size() != 0) begin
            if (mvt_cmds[0].pre_idle > 0) begin
               mvt_cmds[0].pre_idle = mvt_cmds[0].pre_idle - 1;
            end else if (!(mvt_cmds[0].wait_drain && transform_due.size() != 0)) begin
               cmd = mvt_cmds.pop_front();
               next_valid = 1'b1;
               req_mode <= cmd.mode;
               req_elem_index <= cmd.idx;
               req_elem_value <= cmd.value;
               req_vec_x <= cmd.vec[0];
               req_vec_y <= cmd.vec[1];
               req_vec_z <= cmd.vec[2];
               req_vec_w <= cmd.vec[3];
            end
         end
      end
      req_valid <= next_valid;
   end

   // receiver: random stalls, free stretches and one long hold-off
   always @(negedge clock) begin
      logic next_stall;
      int   pick;
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         next_stall = 1'b1;
      end else if (!holdoff_done && n_accepted >= HOLD_AT) begin
         hold_left = HOLD_LEN;
         holdoff_done = 1'b1;
         next_stall = 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         next_stall = 1'b1;
      end else if (free_left > 0) begin
         free_left = free_left - 1;
         next_stall = 1'b0;
      end else begin
         pick = $urandom_range(0, 99);
         next_stall = 1'b0;
         if (pick < 25) begin
            free_left = $urandom_range(20, 60);
         end else if (pick >= 70 && pick < 96) begin
            stall_left = $urandom_range(0, 2);
            next_stall = 1'b1;
         end else if (pick >= 96) begin
            stall_left = $urandom_range(10, 40);
            next_stall = 1'b1;
         end
      end
      rsp_stall <= next_stall;
   end

   // monitor: track accepted transactions and check each response
   always @(posedge clock) begin
      xform_result_type want;
      word_type         got [DIM];
      int               i;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            n_accepted++;
            if (req_mode == MODE_LOAD) begin
               shadow_matrix[req_elem_index] = req_elem_value;
               n_loads++;
            end else begin
               transform_due.push_back(
                  apply_matrix('{req_vec_x, req_vec_y, req_vec_z, req_vec_w}));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (transform_due.size() == 0) begin
               $error("response with no transform outstanding");
               n_errors++;
            end else begin
               want = transform_due.pop_front();
               got = '{rsp_res_x, rsp_res_y, rsp_res_z, rsp_res_w};
               n_checked++;
               if (rsp_saturated) begin
                  n_clipped++;
               end
               for (i = 0; i < DIM; i++) begin
                  if (got[i] !== want.comp[i]) begin
                     $error("%s: expected %0d, actual %0d", comp_name[i], want.comp[i],
                            got[i]);
                     n_errors++;
                  end
               end
               if (rsp_saturated !== want.sat) begin
                  $error("saturated: expected %0b, actual %0b", want.sat, rsp_saturated);
                  n_errors++;
               end
            end
         end
      end
   end

   // stimulus, reset and end of run
   initial begin
      int i;
      int pick;
      for (i = 0; i < ELEMS; i++) begin
         shadow_matrix[i] = '0;
      end
      for (i = 0; i < DIM; i++) begin
         shadow_matrix[DIM*i + i] = ONE_Q;
      end

      // directed: identity after reset, clipping both ways, floor rounding
      no_gaps = 1'b1;
      push_xform(W_MAX, W_MIN, '0, -32'sd1);
      push_xform(32'sd1, -32'sd1, ONE_Q, -ONE_Q);
      push_load(4'd0, W_MAX);
      push_load(4'd15, W_MIN);
      push_load(4'd4, W_MAX);
      push_xform(W_MAX, W_MAX, 32'sd1, 32'sd1);
      push_xform(W_MIN, W_MIN, W_MIN, W_MIN);
      drain_next = 1'b1;
      push_load(4'd0, 32'sd1);
      push_load(4'd4, '0);
      push_xform(-32'sd1, '0, '0, '0);
      push_xform(32'sd1, '0, '0, '0);
      // a full row of minimum values overflows a 64-bit sum
      push_load(4'd0, W_MIN);
      push_load(4'd4, W_MIN);
      push_load(4'd8, W_MIN);
      push_load(4'd12, W_MIN);
      push_xform(W_MIN, W_MIN, W_MIN, W_MIN);
      push_xform(W_MAX, W_MAX, W_MAX, W_MAX);
      // load used by the very next transform
      push_load(4'd7, -ONE_Q);
      push_xform(rand_q(), rand_q(), rand_q(), ONE_Q);
      push_xform('0, '0, '0, '0);

      // random: matrix reloads, single element writes, transform streams
      no_gaps = 1'b0;
      drain_next = 1'b1;
      while (mvt_cmds.size() < RAND_ITEMS + 20) begin
         if (mvt_cmds.size() >= HOLD_AT - 40 && mvt_cmds.size() < HOLD_AT + 100) begin
            // back-to-back transforms across the receiver hold-off
            no_gaps = 1'b1;
            push_xform(rand_q(), rand_q(), rand_q(), rand_q());
            if (mvt_cmds.size() == HOLD_AT + 100) begin
               no_gaps = 1'b0;
               drain_next = 1'b1;
            end
         end else begin
            if ($urandom_range(0, 99) < 2) begin
               no_gaps = !no_gaps;
            end
            if ($urandom_range(0, 99) == 0) begin
               drain_next = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
               for (i = 0; i < ELEMS; i++) begin
                  push_load(4'(i), rand_q());
               end
            end else if (pick < 16) begin
               push_load(4'($urandom()), rand_q());
            end else begin
               push_xform(rand_q(), rand_q(), rand_q(), rand_q());
            end
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (mvt_cmds.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (transform_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (12) @(posedge clock);

      $display("covered %0d transactions: %0d element loads, %0d transforms checked",
               n_accepted, n_loads, n_checked);
      $display("%0d responses clipped, %0d mismatches", n_clipped, n_errors);
      if (n_errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
design/mvt_pkg.sv
design/mvt_lane.sv
design/mvt_merge.sv
design/mat4_vector_transform_unit.sv
sim/tb.sv
